// ===== rtl/itra_pkg.sv =====
`default_nettype none

package itra_pkg;

    // Widths fixed by the item and register formats
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int IN_DATA_W          = 32;
    localparam int OUT_DATA_W         = 8;
    localparam int CHAR_W             = 7;
    localparam int DIGIT_W            = 4;
    localparam int RADIX_W            = 5;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 5;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_RADIX    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNSIGNED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER    = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take a new value, clear the digit count
        logic div_step;   // one bit of the serial division
        logic push;       // store the remainder as the next digit
        logic rd;         // read the stack at the current index
        logic out_sign;   // load '-' into the output register
        logic out_digit;  // load the digit read from the stack
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_step;  // the current division step is the final one
        logic quot_zero;  // quotient is zero, no more digits
        logic neg;        // the value is negative
        logic idx_zero;   // the digit being sent is the last one
        logic slot_free;  // output register can take a character
    } sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic lower);
        logic [CHAR_W-1:0] ext;
        logic [CHAR_W-1:0] c;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_TEN) begin
            c = CH_ZERO + ext;
        end
        else if (lower) begin
            c = CH_LOWER_A + ext - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
        end
        else begin
            c = CH_UPPER_A + ext - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_radix_ascii_top.sv =====
`default_nettype none

// Integer to radix text. Each input item carries one integer; its low
// VALUE_BITS bits are converted to text in the radix held by the radix
// register (values below 2 act as 2, above 16 act as 16). The characters
// leave as one output item each, most significant first, as 7-bit ASCII in
// the low bits of m_tdata, with m_tlast on the final character. Unless
// unsigned mode is set, a value with its top bit set is negative and gets a
// leading '-' followed by the digits of its magnitude; the most negative
// value converts exactly. Lowercase mode selects a-f over A-F; zero gives
// "0". Configuration registers: index 0 radix (reset 10), index 1 unsigned
// mode (reset 0), index 2 lowercase (reset 0); write them only while no
// conversion is in flight. One item at a time is converted: digits come from
// a bit-serial restoring divider, one division step per quotient bit, and
// each remainder is pushed onto the digit stack; each character is then
// sent as a stack read followed by an output load, which waits for a free
// output register. The output register lets the next item be accepted while
// the last character still waits for the sink.

module integer_to_radix_ascii_top #(
    parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [itra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [itra_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [itra_pkg::IN_DATA_W-1:0]   s_tdata,  // [31:0] value_bits
    // output items, one per character
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [itra_pkg::OUT_DATA_W-1:0]  m_tdata,  // [6:0] char_code, [7] zero
    output logic                                  m_tlast   // last_char
);
    import itra_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [CHAR_W-1:0] char_code;

    // Sequence the conversion: divide, push digits, then send them in reverse
    itra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the registers, the divider, the digit stack and the output register
    itra_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .char_code (char_code),
        .last_char (m_tlast)
    );

    // Pad the character to a whole byte
    assign m_tdata = {{(OUT_DATA_W-CHAR_W){1'b0}}, char_code};

endmodule

`default_nettype wire

// ===== rtl/itra_ram.sv =====
`default_nettype none

module itra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/itra_datapath.sv =====
`default_nettype none

module itra_datapath #(
    parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [itra_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [itra_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [itra_pkg::IN_DATA_W-1:0]   in_data,
    input  wire itra_pkg::cmd_t                   cmd,
    output itra_pkg::sts_t                        sts,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic      [itra_pkg::CHAR_W-1:0]      char_code,
    output logic                                  last_char
);
    import itra_pkg::*;

    localparam int ADDR_W = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    // Configuration registers
    logic [RADIX_W-1:0] radix_reg;
    logic               unsigned_reg;
    logic               lower_reg;

    // Conversion state
    logic [VALUE_BITS-1:0] mag_reg;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [ADDR_W-1:0]     bit_cnt_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]     idx_reg;
    logic                  neg_reg;

    // Output register
    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;

    logic [VALUE_BITS-1:0] in_value;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] mag_init;
    logic [RADIX_W-1:0]    base;
    logic [RADIX_W-1:0]    trial;
    logic                  q_bit;
    logic [DIGIT_W-1:0]    rem_next;
    logic [DIGIT_W-1:0]    ram_rdata;

    generate
        if (VALUE_BITS <= IN_DATA_W) begin : g_narrow
            assign in_value = in_data[VALUE_BITS-1:0];
        end
        else begin : g_wide
            assign in_value = {{(VALUE_BITS-IN_DATA_W){1'b0}}, in_data};
        end
    endgenerate

    always_comb
    begin
        in_neg   = !unsigned_reg && in_value[VALUE_BITS-1];
        mag_init = in_neg ? ({VALUE_BITS{1'b0}} - in_value) : in_value;

        if (radix_reg < RADIX_MIN)
        begin
            base = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            base = RADIX_MAX;
        end
        else
        begin
            base = radix_reg;
        end

        // restoring step: shift in the next dividend bit, subtract if it fits
        trial    = {rem_reg, mag_reg[VALUE_BITS-1]};
        q_bit    = (trial >= base);
        rem_next = q_bit ? DIGIT_W'(trial - base) : trial[DIGIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= RADIX_RESET;
            unsigned_reg <= 1'b0;
            lower_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIX:    radix_reg    <= cfg_data;
                REG_UNSIGNED: unsigned_reg <= cfg_data[0];
                REG_LOWER:    lower_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg     <= '0;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            neg_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            mag_reg     <= mag_init;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            neg_reg     <= in_neg;
        end
        else if (cmd.div_step)
        begin
            mag_reg     <= {mag_reg[VALUE_BITS-2:0], q_bit};
            bit_cnt_reg <= bit_cnt_reg + ADDR_W'(1);
        end
        else if (cmd.push)
        begin
            bit_cnt_reg <= '0;
            count_reg   <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.push)
        begin
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
        end

        if (cmd.push)
        begin
            idx_reg <= count_reg[ADDR_W-1:0];
        end
        else if (cmd.out_digit)
        begin
            idx_reg <= idx_reg - ADDR_W'(1);
        end
    end

    itra_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rem_reg),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_sign || cmd.out_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_sign)
        begin
            char_reg <= CH_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.out_digit)
        begin
            char_reg <= digit_char(ram_rdata, lower_reg);
            last_reg <= (idx_reg == '0);
        end
    end

    always_comb
    begin
        sts.last_step = (bit_cnt_reg == ADDR_W'(VALUE_BITS - 1));
        sts.quot_zero = (mag_reg == '0);
        sts.neg       = neg_reg;
        sts.idx_zero  = (idx_reg == '0);
        sts.slot_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // The stack never fills past its depth
    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (count_reg < CNT_W'(VALUE_BITS)))
        else $error("digit stack overflow");

    // A stored digit is always below the radix
    a_digit_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> ({1'b0, rem_reg} < base))
        else $error("remainder not below radix");

    // Hold a waiting character until the sink takes it
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
            (out_valid_reg && $stable(char_reg) && $stable(last_reg)))
        else $error("output item changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/itra_ctrl.sv =====
`default_nettype none

module itra_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire itra_pkg::sts_t sts,
    output itra_pkg::cmd_t      cmd
);
    import itra_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_PUSH = 6'b000100,
        ST_SIGN = 6'b001000,
        ST_READ = 6'b010000,
        ST_LOAD = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.last_step)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (!sts.quot_zero)
                begin
                    state_next = ST_DIV;
                end
                else if (sts.neg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_SIGN:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_sign = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_digit = 1'b1;
                    state_next    = sts.idx_zero ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A stack read is always followed directly by the load state that uses its data
    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_LOAD))
        else $error("stack read not followed by load");

    // Never overwrite a character the sink has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_sign || cmd.out_digit) |-> sts.slot_free)
        else $error("output register overwritten");

    // A non-negative value goes straight from its last digit to sending
    a_pos_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && sts.quot_zero && !sts.neg) |=> (state_reg == ST_READ))
        else $error("missed transition to send");

endmodule

`default_nettype wire

// ===== tb/integer_to_radix_ascii_top_tb.sv =====
`default_nettype none

module integer_to_radix_ascii_top_tb;
    import itra_pkg::*;

    localparam int VALUE_W         = VALUE_BITS_DEFAULT;
    // Longest quiet stretch of a correct run is one radix-2 conversion plus
    // sink stalls; allow many times that.
    localparam int STALL_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 64;
    localparam int SEGMENTS        = 6;
    localparam int ITEMS_PER_SEG   = 5;
    // Index with no register behind it; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // Tracks the configuration, predicts the text of every accepted value
    // and compares the characters as they leave the block.
    class text_scoreboard;
        logic [RADIX_W-1:0] radix;
        logic               unsigned_mode;
        logic               lowercase;
        text_char_t         pending_chars[$];
        int                 mismatches;

        function new();
            radix         = RADIX_RESET;
            unsigned_mode = 1'b0;
            lowercase     = 1'b0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RADIX:    radix         = data[RADIX_W-1:0];
                REG_UNSIGNED: unsigned_mode = data[0];
                REG_LOWER:    lowercase     = data[0];
                default:      ;
            endcase
        endfunction

        function void note_value(logic [IN_DATA_W-1:0] raw);
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] base;
            logic [DIGIT_W-1:0] digits[VALUE_W];
            logic [CHAR_W-1:0]  letter_a;
            logic               neg;
            int                 n;
            int                 k;
            text_char_t         c;
            // Clamp the radix into two..sixteen
            if (radix < RADIX_MIN)
                base = VALUE_W'(RADIX_MIN);
            else if (radix > RADIX_MAX)
                base = VALUE_W'(RADIX_MAX);
            else
                base = VALUE_W'(radix);
            neg = !unsigned_mode && raw[VALUE_W-1];
            mag = neg ? (~raw[VALUE_W-1:0] + 1'b1) : raw[VALUE_W-1:0];
            n = 0;
            do
            begin
                digits[n] = DIGIT_W'(mag % base);
                n++;
                mag = mag / base;
            end
            while (mag != 0);
            if (neg)
            begin
                c.code = CH_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
            end
            letter_a = lowercase ? CH_LOWER_A : CH_UPPER_A;
            // Emit most significant digit first
            for (k = n - 1; k >= 0; k--)
            begin
                if (digits[k] < DIGIT_TEN)
                    c.code = CH_ZERO + {3'b000, digits[k]};
                else
                    c.code = letter_a + {3'b000, digits[k]} - {3'b000, DIGIT_TEN};
                c.last = (k == 0);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [OUT_DATA_W-1:0] data, logic last);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual data=%h last=%b",
                         $time, data, last);
                mismatches++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (data !== {1'b0, want.code} || last !== want.last)
                begin
                    $display("%0t: char mismatch: expected data=%h last=%b, actual data=%h last=%b",
                             $time, {1'b0, want.code}, want.last, data, last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;   // [31:0] value_bits
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // [6:0] char_code, [7] zero
    logic                   m_tlast;          // last_char

    int             src_idle_pct  = 28;
    int             sink_idle_pct = 87;
    int             idle_cycles   = 0;
    text_scoreboard sb;

    integer_to_radix_ascii_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the sink at random, once per cycle
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Check outgoing characters before noting a new value on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_value(s_tdata);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one value, with random idle cycles ahead of it; return on accept
    task automatic send_value(input logic [IN_DATA_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off the sender until every predicted character has left; wait
    // past the edge first so a value accepted there is already noted
    task automatic drain_chars();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending_chars.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register once the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        drain_chars();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // One idling profile: several random settings, each with a burst of values
    task automatic run_phase(input int src_pct, input int sink_pct);
        logic [CFG_DATA_W-1:0] radix_sel;
        logic [IN_DATA_W-1:0]  value;
        int                    seg;
        int                    i;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            // Mostly legal radixes, sometimes any code the register holds
            if ($urandom_range(3) == 0)
                radix_sel = CFG_DATA_W'($urandom_range(31));
            else
                radix_sel = CFG_DATA_W'($urandom_range(RADIX_MAX, RADIX_MIN));
            write_reg(REG_RADIX, radix_sel);
            write_reg(REG_UNSIGNED, CFG_DATA_W'($urandom_range(31)));
            write_reg(REG_LOWER, CFG_DATA_W'($urandom_range(31)));
            for (i = 0; i < ITEMS_PER_SEG + (seg % 2); i++)
            begin
                case ($urandom_range(5))
                    0: value = IN_DATA_W'($urandom_range(255));
                    1: value = ~IN_DATA_W'($urandom_range(255));
                    2:
                    begin
                        case ($urandom_range(3))
                            0:       value = '0;
                            1:       value = '1;
                            2:       value = {1'b1, {(IN_DATA_W-1){1'b0}}};
                            default: value = {1'b0, {(IN_DATA_W-1){1'b1}}};
                        endcase
                    end
                    default: value = $urandom;
                endcase
                // Now and then let the block run dry before the next value
                if ($urandom_range(15) == 0)
                    drain_chars();
                send_value(value);
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: decimal, signed, uppercase
        send_value(32'h0000_0000);
        send_value(32'h0000_0001);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'hFFFF_CFC7);

        // Hex with letters, lowercase then uppercase, signed then unsigned
        write_reg(REG_RADIX, 5'd16);
        write_reg(REG_LOWER, 5'd1);
        send_value(32'hDEAD_BEEF);
        send_value(32'h0ABC_DEF9);
        write_reg(REG_UNSIGNED, 5'b11111);
        send_value(32'hFEDC_BA98);
        write_reg(REG_LOWER, 5'b11110);
        send_value(32'hFEDC_BA98);

        // Binary: longest unsigned text, then the most negative value
        write_reg(REG_RADIX, 5'd2);
        send_value(32'hFFFF_FFFF);
        write_reg(REG_UNSIGNED, 5'd0);
        send_value(32'h8000_0000);
        send_value(32'h0000_0000);

        // Radix codes outside two..sixteen clamp to the nearest end
        write_reg(REG_RADIX, 5'd0);
        send_value(32'h0000_0006);
        write_reg(REG_RADIX, 5'd1);
        send_value(32'hFFFF_FFFA);
        write_reg(REG_RADIX, 5'd17);
        send_value(32'hFFFF_FFFF);
        write_reg(REG_RADIX, 5'd31);
        send_value(32'h7FFF_FFFF);

        // A write to the unused index must leave the radix alone
        write_reg(REG_SPARE, 5'd5);
        send_value(32'h7FFF_FFFF);
        write_reg(REG_RADIX, 5'd3);
        write_reg(REG_UNSIGNED, 5'd1);
        send_value(32'hFFFF_FFFF);

        run_phase(28, 87);
        run_phase(87, 28);
        run_phase(0, 0);

        drain_chars();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_chars.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
